@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console character writer.
// Holds screen geometry, request and character codes, item structs and
// the command/status structs between controller and datapath.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Character and attribute constants
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    // Memory operation codes
    typedef logic [2:0] t_mem_op;
    localparam t_mem_op MOP_NONE   = 3'd0;
    localparam t_mem_op MOP_PUT    = 3'd1;
    localparam t_mem_op MOP_BS     = 3'd2;
    localparam t_mem_op MOP_READ   = 3'd3;
    localparam t_mem_op MOP_INIT   = 3'd4;
    localparam t_mem_op MOP_CLEAR  = 3'd5;
    localparam t_mem_op MOP_SCROLL = 3'd6;

    // Cursor operation codes
    typedef logic [2:0] t_cur_op;
    localparam t_cur_op COP_HOLD   = 3'd0;
    localparam t_cur_op COP_ADV    = 3'd1;
    localparam t_cur_op COP_BACK   = 3'd2;
    localparam t_cur_op COP_LINE   = 3'd3;
    localparam t_cur_op COP_HOME   = 3'd4;
    localparam t_cur_op COP_BOTTOM = 3'd5;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       char_code;
        logic [7:0]       attr;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             scrolled;
    } t_out_item;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clr;
        logic    cnt_inc;
        t_mem_op mem_op;
        t_cur_op cur_op;
        logic    scr_set;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       is_nl;
        logic       is_bs;
        logic       col_zero;
        logic       col_full;
        logic       row_last;
        logic       fill_end;
        logic       scroll_end;
        logic       out_free;
    } t_dp_stat;

endpackage

@@ rtl/text_console_char_writer_core.sv @@
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (and tcw_ram inside tcw_dp).
//
// Usage:
//   Request channel: i_in_valid / o_in_ready / i_in_item (put, clear, read).
//   Result channel:  o_out_valid / i_out_ready / o_out_item, one item per
//   request, in request order.
//   The screen store is an 80 x 25 cell RAM with one write and one read port.
//   After reset the block runs a clearing pass that fills every
//   cell with a space in attribute 0x0F; o_in_ready stays low meanwhile.
//   Steps from acceptance to result valid (result register free):
//     put of a plain byte, backspace, newline without scroll: EXEC loads
//     the result; a new request is taken only once back in IDLE;
//     a wrap at the right edge adds an EXEC step for the line advance;
//     read: EXEC starts the registered RAM read, RDWAIT loads the result;
//     scroll: a SCROLL pass, one cell copied per cycle on the RAM ports;
//     clear: a CLEAR pass, one cell written per cycle.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls and a second result is ready,
//   the block holds that result and stops accepting until the register frees.
module text_console_char_writer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcw_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcw_pkg::t_out_item o_out_item
);

    tcw_pkg::t_dp_cmd  w_cmd;
    tcw_pkg::t_dp_stat w_stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tcw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tcw_dp.sv @@
// Datapath of the text console writer: request register, cursor, sweep
// counter, screen store and result register. Uses tcw_pkg and tcw_ram.
module tcw_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_in_item  i_in_item,
    input  tcw_pkg::t_dp_cmd   i_cmd,
    output tcw_pkg::t_dp_stat  o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output tcw_pkg::t_out_item o_out_item
);

    tcw_pkg::t_in_item              r_item;
    tcw_pkg::t_out_item             r_out_item;
    logic [tcw_pkg::COL_W-1:0]      r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]      r_row, n_row;
    logic                           r_scr, n_scr;
    logic [tcw_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_rd_hit;
    logic                           r_out_valid;

    logic                           w_we, w_re;
    logic [tcw_pkg::ADDR_W-1:0]     w_waddr, w_raddr;
    logic [tcw_pkg::CELL_W-1:0]     w_wdata, w_rdata;
    logic [tcw_pkg::CNT_W-1:0]      w_cnt_up, w_cnt_dn;
    logic [tcw_pkg::COL_W-1:0]      w_col_dn;
    logic                           w_rd_in_range;
    logic [tcw_pkg::CELL_W-1:0]     w_blank;

    // Linear cell address from row and column
    function automatic logic [tcw_pkg::ADDR_W-1:0] f_cell_addr(
        input logic [tcw_pkg::ROW_W-1:0] row,
        input logic [tcw_pkg::COL_W-1:0] col
    );
        logic [31:0] v;
        v = 32'(row) * 32'(tcw_pkg::COLUMNS) + 32'(col);
        return v[tcw_pkg::ADDR_W-1:0];
    endfunction

    assign w_cnt_up = r_cnt + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
    assign w_cnt_dn = r_cnt - 1'b1;
    assign w_col_dn = r_col - 1'b1;
    assign w_blank  = {r_item.attr, tcw_pkg::CH_SPACE};
    assign w_rd_in_range = (r_item.read_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) &&
                           (r_item.read_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));

    // Store port control per memory operation
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = '0;
        w_raddr = '0;
        w_wdata = w_blank;
        unique case (i_cmd.mem_op)
            tcw_pkg::MOP_NONE: begin
            end
            tcw_pkg::MOP_PUT: begin
                w_we    = 1'b1;
                w_waddr = f_cell_addr(r_row, r_col);
                w_wdata = {r_item.attr, r_item.char_code};
            end
            tcw_pkg::MOP_BS: begin
                w_we    = 1'b1;
                w_waddr = f_cell_addr(r_row, w_col_dn);
            end
            tcw_pkg::MOP_READ: begin
                w_re    = w_rd_in_range;
                w_raddr = f_cell_addr(r_item.read_row, r_item.read_col);
            end
            tcw_pkg::MOP_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[tcw_pkg::ADDR_W-1:0];
                w_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::MOP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[tcw_pkg::ADDR_W-1:0];
            end
            tcw_pkg::MOP_SCROLL: begin
                // read one row ahead, write the data read last cycle
                w_re    = r_cnt < tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                w_raddr = w_cnt_up[tcw_pkg::ADDR_W-1:0];
                w_we    = r_cnt != '0;
                w_waddr = w_cnt_dn[tcw_pkg::ADDR_W-1:0];
                w_wdata = (r_cnt <= tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) ?
                          w_rdata : w_blank;
            end
            default: begin
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Cursor next value
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_cmd.cur_op)
            tcw_pkg::COP_HOLD: begin
            end
            tcw_pkg::COP_ADV: begin
                n_col = r_col + 1'b1;
            end
            tcw_pkg::COP_BACK: begin
                n_col = w_col_dn;
            end
            tcw_pkg::COP_LINE: begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end
            tcw_pkg::COP_HOME: begin
                n_col = '0;
                n_row = '0;
            end
            tcw_pkg::COP_BOTTOM: begin
                n_col = '0;
                n_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
            end
            default: begin
            end
        endcase
    end

    assign n_scr = i_cmd.load_item ? 1'b0 : (i_cmd.scr_set | r_scr);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_scr       <= 1'b0;
            r_cnt       <= '0;
            r_rd_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_scr <= n_scr;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.load_item) begin
                r_rd_hit <= 1'b0;
            end else if (i_cmd.mem_op == tcw_pkg::MOP_READ) begin
                r_rd_hit <= w_rd_in_range;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.out_load) begin
            r_out_item.cursor_col <= n_col;
            r_out_item.cursor_row <= n_row;
            r_out_item.cell_char  <= r_rd_hit ? w_rdata[7:0] : 8'h00;
            r_out_item.cell_attr  <= r_rd_hit ? w_rdata[15:8] : 8'h00;
            r_out_item.scrolled   <= n_scr;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.req        = r_item.req_type;
        o_stat.is_nl      = r_item.char_code == tcw_pkg::CH_NEWLINE;
        o_stat.is_bs      = r_item.char_code == tcw_pkg::CH_BACKSPACE;
        o_stat.col_zero   = r_col == '0;
        o_stat.col_full   = r_col >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
        o_stat.row_last   = r_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        o_stat.fill_end   = r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1);
        o_stat.scroll_end = r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/tcw_ctrl.sv @@
// Controller state machine of the text console writer.
// Drives tcw_dp through tcw_pkg::t_dp_cmd and reads tcw_pkg::t_dp_stat.
module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcw_pkg::t_dp_stat i_stat,
    output tcw_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]       r_state, n_state;
    tcw_pkg::t_dp_cmd cmd;
    logic             w_ready;

    always_comb begin
        cmd     = '0;
        w_ready = 1'b0;
        n_state = r_state;
        unique case (r_state)
            // fill the store with blanks after reset
            ST_INIT: begin
                cmd.mem_op  = tcw_pkg::MOP_INIT;
                cmd.cnt_inc = 1'b1;
                if (i_stat.fill_end) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_stat.req)
                    tcw_pkg::REQ_PUT: begin
                        if (i_stat.is_nl || (!i_stat.is_bs && i_stat.col_full)) begin
                            // line advance; the last row scrolls instead
                            if (i_stat.row_last) begin
                                cmd.scr_set = 1'b1;
                                cmd.cnt_clr = 1'b1;
                                n_state     = ST_SCROLL;
                            end else begin
                                cmd.cur_op = tcw_pkg::COP_LINE;
                                if (i_stat.is_nl) begin
                                    if (i_stat.out_free) begin
                                        cmd.out_load = 1'b1;
                                        n_state      = ST_IDLE;
                                    end else begin
                                        n_state = ST_DONE;
                                    end
                                end
                            end
                        end else begin
                            if (i_stat.is_bs) begin
                                if (!i_stat.col_zero) begin
                                    cmd.mem_op = tcw_pkg::MOP_BS;
                                    cmd.cur_op = tcw_pkg::COP_BACK;
                                end
                            end else begin
                                cmd.mem_op = tcw_pkg::MOP_PUT;
                                cmd.cur_op = tcw_pkg::COP_ADV;
                            end
                            if (i_stat.out_free) begin
                                cmd.out_load = 1'b1;
                                n_state      = ST_IDLE;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                    end
                    tcw_pkg::REQ_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = ST_CLEAR;
                    end
                    tcw_pkg::REQ_READ: begin
                        cmd.mem_op = tcw_pkg::MOP_READ;
                        n_state    = ST_RDWAIT;
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            cmd.out_load = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                endcase
            end
            // shift rows up, blank the bottom row
            ST_SCROLL: begin
                cmd.mem_op  = tcw_pkg::MOP_SCROLL;
                cmd.cnt_inc = 1'b1;
                if (i_stat.scroll_end) begin
                    cmd.cur_op  = tcw_pkg::COP_BOTTOM;
                    cmd.cnt_clr = 1'b1;
                    if (!i_stat.is_nl) begin
                        n_state = ST_EXEC;
                    end else if (i_stat.out_free) begin
                        cmd.out_load = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.mem_op  = tcw_pkg::MOP_CLEAR;
                cmd.cnt_inc = 1'b1;
                if (i_stat.fill_end) begin
                    cmd.cur_op  = tcw_pkg::COP_HOME;
                    cmd.cnt_clr = 1'b1;
                    if (i_stat.out_free) begin
                        cmd.out_load = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RDWAIT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // result register still occupied
            ST_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = w_ready;

endmodule

@@ tb/text_console_char_writer_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_console_char_writer_core.
// Depends on tcw_pkg and the core RTL; predicts each result from a local screen copy.
module text_console_char_writer_core_test;

    localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
    localparam int         ITEMS_PER_PASS = 317;
    localparam int         WATCHDOG_LIMIT = 12000;
    localparam int         TAIL_CYCLES    = 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    tcw_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    tcw_pkg::t_out_item out_item;

    // Predictor state: cell = {attr, char}
    logic [15:0] screen_mem [tcw_pkg::CELLS];
    int          cur_col;
    int          cur_row;

    tcw_pkg::t_in_item  pending_reqs [$];
    tcw_pkg::t_out_item expected_results [$];

    logic in_taken = 1'b0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   queued_total;
    int   results_seen;
    int   gen_count;
    int   mismatch_count;
    int   stall_cycles;

    text_console_char_writer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Linear cell index from row and column
    function automatic logic [tcw_pkg::ADDR_W-1:0] cell_index(input int row, input int col);
        return tcw_pkg::ADDR_W'(row * tcw_pkg::COLUMNS + col);
    endfunction

    // Cursor to the start of the next row; scroll when it falls off the bottom
    function automatic logic line_feed(input logic [7:0] at);
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row >= tcw_pkg::ROWS) begin
            for (i = 0; i + tcw_pkg::COLUMNS < tcw_pkg::CELLS; i++)
                screen_mem[cell_index(0, i)] = screen_mem[cell_index(0, i + tcw_pkg::COLUMNS)];
            for (i = 0; i < tcw_pkg::COLUMNS; i++)
                screen_mem[cell_index(tcw_pkg::ROWS - 1, i)] = {at, tcw_pkg::CH_SPACE};
            cur_row = tcw_pkg::ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the screen copy and return the expected result
    function automatic tcw_pkg::t_out_item console_apply(input tcw_pkg::t_in_item req);
        tcw_pkg::t_out_item res;
        int                 i;
        res = '0;
        case (req.req_type)
            tcw_pkg::REQ_PUT: begin
                if (req.char_code == tcw_pkg::CH_NEWLINE) begin
                    res.scrolled = line_feed(req.attr);
                end else if (req.char_code == tcw_pkg::CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen_mem[cell_index(cur_row, cur_col)] =
                            {req.attr, tcw_pkg::CH_SPACE};
                    end
                end else begin
                    if (cur_col >= tcw_pkg::COLUMNS)
                        res.scrolled = line_feed(req.attr);
                    screen_mem[cell_index(cur_row, cur_col)] = {req.attr, req.char_code};
                    cur_col++;
                end
            end
            tcw_pkg::REQ_CLEAR: begin
                for (i = 0; i < tcw_pkg::CELLS; i++)
                    screen_mem[cell_index(0, i)] = {req.attr, tcw_pkg::CH_SPACE};
                cur_col = 0;
                cur_row = 0;
            end
            tcw_pkg::REQ_READ: begin
                if (int'(req.read_row) < tcw_pkg::ROWS && int'(req.read_col) < tcw_pkg::COLUMNS)
                    {res.cell_attr, res.cell_char} =
                        screen_mem[cell_index(int'(req.read_row), int'(req.read_col))];
            end
            default: ;
        endcase
        res.cursor_col = tcw_pkg::COL_W'(cur_col);
        res.cursor_row = tcw_pkg::ROW_W'(cur_row);
        return res;
    endfunction

    task automatic check_result(input tcw_pkg::t_out_item want,
                                input tcw_pkg::t_out_item got);
        if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
            got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
            got.scrolled !== want.scrolled) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t result %0d: expected col=%0d row=%0d char=%h attr=%h scr=%b",
                         $realtime, results_seen, want.cursor_col, want.cursor_row,
                         want.cell_char, want.cell_attr, want.scrolled);
                $display("    got col=%0d row=%0d char=%h attr=%h scr=%b",
                         got.cursor_col, got.cursor_row, got.cell_char, got.cell_attr,
                         got.scrolled);
            end
        end
    endtask

    // Monitor: check results, predict accepted requests, watchdog
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t unexpected result: col=%0d row=%0d char=%h attr=%h",
                                 $realtime, out_item.cursor_col, out_item.cursor_row,
                                 out_item.cell_char, out_item.cell_attr);
                end else begin
                    check_result(expected_results.pop_front(), out_item);
                    results_seen++;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(console_apply(in_item));
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Driver: request and result-ready changes on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_reqs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic queue_req(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [7:0] at, input logic [4:0] rr,
                             input logic [6:0] rc);
        tcw_pkg::t_in_item it;
        it.req_type  = kind;
        it.char_code = ch;
        it.attr      = at;
        it.read_row  = rr;
        it.read_col  = rc;
        pending_reqs.push_back(it);
        queued_total++;
        if (kind != REQ_UNKNOWN)
            gen_count++;
    endtask

    task automatic put_byte(input logic [7:0] ch, input logic [7:0] at);
        queue_req(tcw_pkg::REQ_PUT, ch, at, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_at(input logic [4:0] rr, input logic [6:0] rc);
        queue_req(tcw_pkg::REQ_READ, 8'($urandom), 8'($urandom), rr, rc);
    endtask

    task automatic clear_with(input logic [7:0] at);
        queue_req(tcw_pkg::REQ_CLEAR, 8'($urandom), at, 5'($urandom), 7'($urandom));
    endtask

    // Printable-ish byte that is neither newline nor backspace
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == tcw_pkg::CH_NEWLINE || b == tcw_pkg::CH_BACKSPACE)
            b = b ^ 8'h40;
        return b;
    endfunction

    // Extremes, every request kind, edge cases of the cursor
    task automatic queue_directed();
        read_at(5'd0, 7'd0);
        read_at(5'(tcw_pkg::ROWS - 1), 7'(tcw_pkg::COLUMNS - 1));
        read_at(5'(tcw_pkg::ROWS), 7'd0);
        read_at(5'd0, 7'(tcw_pkg::COLUMNS));
        read_at(5'h1F, 7'h7F);
        put_byte(8'hFF, 8'hFF);
        put_byte(8'h00, 8'h00);
        read_at(5'd0, 7'd0);
        read_at(5'd0, 7'd1);
        put_byte(tcw_pkg::CH_BACKSPACE, 8'hA5);
        read_at(5'd0, 7'd1);
        queue_req(REQ_UNKNOWN, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        put_byte(tcw_pkg::CH_NEWLINE, 8'h3C);
        put_byte(tcw_pkg::CH_BACKSPACE, 8'h11);
        put_byte(8'h78, 8'h07);
        clear_with(8'h00);
        read_at(5'd1, 7'd0);
        put_byte(tcw_pkg::CH_BACKSPACE, 8'h22);
        clear_with(8'hFF);
        read_at(5'(tcw_pkg::ROWS - 1), 7'(tcw_pkg::COLUMNS - 1));
        put_byte(8'h7F, 8'h80);
    endtask

    // Enough newlines to reach the bottom, then a line that wraps there
    task automatic queue_bottom_run();
        int k;
        for (k = 0; k < tcw_pkg::ROWS + 1; k++)
            put_byte(tcw_pkg::CH_NEWLINE, 8'($urandom));
        for (k = 0; k < tcw_pkg::COLUMNS + 5; k++)
            put_byte(text_byte(), 8'($urandom));
        for (k = 0; k < 5; k++)
            read_at(5'(tcw_pkg::ROWS - 1), 7'(k));
        read_at(5'(tcw_pkg::ROWS - 2), 7'(tcw_pkg::COLUMNS - 1));
    endtask

    // Mostly text lines and reads near the text, some noise
    task automatic queue_traffic(input int target);
        int         kind;
        int         len;
        int         k;
        logic [7:0] line_attr;
        while (gen_count < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 95) :
                                                    $urandom_range(0, 25);
                line_attr = 8'($urandom);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 14) == 0)
                        put_byte(tcw_pkg::CH_BACKSPACE, line_attr);
                    else if ($urandom_range(0, 3) == 0)
                        put_byte(text_byte(), 8'($urandom));
                    else
                        put_byte(text_byte(), line_attr);
                end
                if ($urandom_range(0, 4) != 0)
                    put_byte(tcw_pkg::CH_NEWLINE, line_attr);
            end else if (kind < 75) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 2))
                        0: read_at(5'($urandom_range(tcw_pkg::ROWS - 3, tcw_pkg::ROWS - 1)),
                                   7'($urandom_range(0, 15)));
                        1: read_at(5'($urandom_range(0, 3)), 7'($urandom_range(0, 15)));
                        default: read_at(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
                    endcase
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    put_byte(tcw_pkg::CH_BACKSPACE, 8'($urandom));
            end else if (kind < 92) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    put_byte(tcw_pkg::CH_NEWLINE, 8'($urandom));
            end else if (kind < 97) begin
                queue_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                          5'($urandom), 7'($urandom));
            end else begin
                clear_with(8'($urandom));
            end
        end
    endtask

    // Stimulus: three passes with different idling, each drained before the next
    initial begin
        int pass;
        int i;
        for (i = 0; i < tcw_pkg::CELLS; i++)
            screen_mem[cell_index(0, i)] = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
        cur_col        = 0;
        cur_row        = 0;
        queued_total   = 0;
        results_seen   = 0;
        gen_count      = 0;
        mismatch_count = 0;

        for (pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (pass == 0) begin
                queue_directed();
                queue_bottom_run();
            end
            queue_traffic(ITEMS_PER_PASS * (pass + 1));
            if (pass == 0) begin
                repeat (11) @(negedge clk);
                rst_n <= 1'b1;
            end
            // Sender holds off until every result of this pass has come back
            while (results_seen != queued_total)
                @(negedge clk);
            @(posedge clk);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ text_console_char_writer_core.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_dp.sv
rtl/tcw_ctrl.sv
rtl/text_console_char_writer_core.sv
tb/text_console_char_writer_core_test.sv
